// ===== rtl/rts_pkg.sv =====
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types and constants of the rate task scheduler: field widths,
// register map, reset values and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package rts_pkg;

    // field widths
    localparam int N_TASKS_DEF = 4;
    localparam int TASK_IDX_W  = 2;
    localparam int RATE_W      = 16;
    localparam int TIME_W      = 32;

    // configuration port
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 64;
    localparam int REG_SEL_LSB = 3;
    localparam int REG_SEL_W   = PADDR_W - REG_SEL_LSB;

    localparam logic [REG_SEL_W-1:0] REG_LOOP_RATE  = REG_SEL_W'(0);
    localparam logic [REG_SEL_W-1:0] REG_TASK_RATES = REG_SEL_W'(1);
    localparam logic [REG_SEL_W-1:0] REG_TASK_MAX   = REG_SEL_W'(2);

    // reset values: 400 Hz loop, tasks at 50/100/200/400 Hz,
    // limits of 100/500/200/200 us
    localparam logic [RATE_W-1:0]  LOOP_RATE_RST  = 16'd400;
    localparam logic [PDATA_W-1:0] TASK_RATES_RST = 64'd112590849684275250;
    localparam logic [PDATA_W-1:0] TASK_MAX_RST   = 64'd56295854368358500;

    // commands from the controller to the datapath
    typedef struct packed {
        logic calc_clear;
        logic div_start;
        logic div_store;
        logic accept;
        logic exec;
        logic scan_step;
        logic load_out;
    } rts_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic calc_last;
        logic exec_to_scan;
        logic scan_stop;
        logic out_free;
    } rts_status_t;

endpackage

// ===== rtl/rate_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// rate_task_scheduler
// Rate-based cooperative scheduler for up to four tasks: tick items grant
// the first due task, finished items record the run, check overrun and
// either end the tick or continue the scan with the following tasks.
// ----------------------------------------------------------------------------
//
//   port group   direction   handshake         payload
//   s_*          in          s_valid/s_ready   mode, budget_us, time_taken_us
//   m_*          out         m_valid/m_ready   grant_valid, grant_task,
//                                              overrun, tick_done, budget_left
//   apb          in/out      psel/penable      loop_rate, task_rates,
//                                              task_max_times
//
// From acceptance to result an item goes through capture, execute, a scan
// that checks one task per step and stops on a due task or past the last,
// and load; a finish that ends the tick or finds no grant skips the scan.
// The output register frees the next item to enter while a result waits; a
// result that cannot enter the output register holds the block in place.
// After reset and after each write of loop_rate or task_rates seen while
// idle or during a rebuild, the interval table is rebuilt by a 16-step
// divider, task by task, with s_ready low.
// Reset is synchronous, active low.
//
module rate_task_scheduler import rts_pkg::*; #(
    parameter int N_TASKS = N_TASKS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [TIME_W-1:0]     s_budget_us,
    input  logic [TIME_W-1:0]     s_time_taken_us,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_grant_valid,
    output logic [TASK_IDX_W-1:0] m_grant_task,
    output logic                  m_overrun,
    output logic                  m_tick_done,
    output logic [TIME_W-1:0]     m_budget_left
);

    logic [RATE_W-1:0]  loop_rate;
    logic [PDATA_W-1:0] task_rates;
    logic [PDATA_W-1:0] task_max_times;
    logic               rate_wr;
    rts_cmd_t           cmd;
    rts_status_t        status;

    // no wait states on the configuration port
    assign pready = 1'b1;

    rts_regs u_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .loop_rate      (loop_rate),
        .task_rates     (task_rates),
        .task_max_times (task_max_times),
        .rate_wr        (rate_wr)
    );

    rts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .rate_wr (rate_wr),
        .status  (status),
        .cmd     (cmd)
    );

    rts_dp #(
        .N_TASKS (N_TASKS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .loop_rate       (loop_rate),
        .task_rates      (task_rates),
        .task_max_times  (task_max_times),
        .s_mode          (s_mode),
        .s_budget_us     (s_budget_us),
        .s_time_taken_us (s_time_taken_us),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_grant_valid   (m_grant_valid),
        .m_grant_task    (m_grant_task),
        .m_overrun       (m_overrun),
        .m_tick_done     (m_tick_done),
        .m_budget_left   (m_budget_left)
    );

endmodule

// ===== rtl/rts_regs.sv =====
// ----------------------------------------------------------------------------
// rts_regs
// Configuration register file behind the APB-style port: loop rate, packed
// task rates and packed overrun limits. Flags writes that change intervals.
// ----------------------------------------------------------------------------
module rts_regs import rts_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic [RATE_W-1:0]     loop_rate,
    output logic [PDATA_W-1:0]    task_rates,
    output logic [PDATA_W-1:0]    task_max_times,
    output logic                  rate_wr
);

    logic [RATE_W-1:0]    loop_rate_reg, loop_rate_next;
    logic [PDATA_W-1:0]   task_rates_reg, task_rates_next;
    logic [PDATA_W-1:0]   task_max_reg, task_max_next;
    logic [REG_SEL_W-1:0] reg_sel;
    logic                 wr_en;

    assign reg_sel = paddr[PADDR_W-1:REG_SEL_LSB];
    assign wr_en   = psel & penable & pwrite;

    // register writes
    always_comb begin
        loop_rate_next  = loop_rate_reg;
        task_rates_next = task_rates_reg;
        task_max_next   = task_max_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_LOOP_RATE:  loop_rate_next  = pwdata[RATE_W-1:0];
                REG_TASK_RATES: task_rates_next = pwdata;
                REG_TASK_MAX:   task_max_next   = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_rate_reg  <= LOOP_RATE_RST;
            task_rates_reg <= TASK_RATES_RST;
            task_max_reg   <= TASK_MAX_RST;
        end else begin
            loop_rate_reg  <= loop_rate_next;
            task_rates_reg <= task_rates_next;
            task_max_reg   <= task_max_next;
        end
    end

    // read mux
    always_comb begin
        case (reg_sel)
            REG_LOOP_RATE:  prdata = {{(PDATA_W-RATE_W){1'b0}}, loop_rate_reg};
            REG_TASK_RATES: prdata = task_rates_reg;
            REG_TASK_MAX:   prdata = task_max_reg;
            default:        prdata = '0;
        endcase
    end

    // a write that changes any interval
    assign rate_wr = wr_en && (reg_sel inside {REG_LOOP_RATE, REG_TASK_RATES});

    assign loop_rate      = loop_rate_reg;
    assign task_rates     = task_rates_reg;
    assign task_max_times = task_max_reg;

endmodule

// ===== rtl/rts_div.sv =====
// ----------------------------------------------------------------------------
// rts_div
// Iterative restoring divider, one quotient bit per cycle, for the 16-bit
// loop rate over a 16-bit task rate. Pulses done with the quotient ready.
// ----------------------------------------------------------------------------
module rts_div import rts_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RATE_W-1:0] dividend,
    input  logic [RATE_W-1:0] divisor,
    output logic              done,
    output logic [RATE_W-1:0] quotient
);

    localparam int DCNT_W = $clog2(RATE_W);
    localparam logic [DCNT_W-1:0] CNT_LAST = DCNT_W'(RATE_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [RATE_W-1:0] rem_reg, rem_next;
    logic [RATE_W-1:0] quo_reg, quo_next;
    logic [RATE_W-1:0] dvs_reg, dvs_next;
    logic [RATE_W:0]   rem_sh;
    logic [RATE_W:0]   rem_diff;
    logic              fits;

    // one restoring step
    assign rem_sh   = {rem_reg, quo_reg[RATE_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign fits     = rem_sh >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? rem_diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
            quo_next = {quo_reg[RATE_W-2:0], fits};
            cnt_next = cnt_reg + DCNT_W'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/rts_dp.sv =====
// ----------------------------------------------------------------------------
// rts_dp
// Scheduler datapath: tick count, last-run ticks, budget, grant state,
// interval table fed by the divider, the one-task-per-cycle scan and the
// result output register.
// ----------------------------------------------------------------------------
module rts_dp import rts_pkg::*; #(
    parameter int N_TASKS = N_TASKS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rts_cmd_t              cmd,
    output rts_status_t           status,
    input  logic [RATE_W-1:0]     loop_rate,
    input  logic [PDATA_W-1:0]    task_rates,
    input  logic [PDATA_W-1:0]    task_max_times,
    input  logic                  s_mode,
    input  logic [TIME_W-1:0]     s_budget_us,
    input  logic [TIME_W-1:0]     s_time_taken_us,
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic                  m_grant_valid,
    output logic [TASK_IDX_W-1:0] m_grant_task,
    output logic                  m_overrun,
    output logic                  m_tick_done,
    output logic [TIME_W-1:0]     m_budget_left
);

    localparam int TIDX_W = (N_TASKS > 1) ? $clog2(N_TASKS) : 1;
    localparam int CNT_W  = $clog2(N_TASKS + 1);

    // scheduler state
    logic [TIME_W-1:0]     tick_reg, tick_next;
    logic [TIME_W-1:0]     prev_run_reg [N_TASKS];
    logic [TIME_W-1:0]     prev_run_next [N_TASKS];
    logic [TIME_W-1:0]     budget_reg, budget_next;
    logic [TASK_IDX_W-1:0] cur_reg, cur_next;
    logic                  pend_reg, pend_next;
    logic [RATE_W-1:0]     interval_reg [N_TASKS];
    logic [RATE_W-1:0]     interval_next [N_TASKS];
    logic [TIDX_W-1:0]     calc_idx_reg, calc_idx_next;
    logic [CNT_W-1:0]      scan_idx_reg, scan_idx_next;

    // latched item and result
    logic                  item_mode_reg, item_mode_next;
    logic [TIME_W-1:0]     item_budget_reg, item_budget_next;
    logic [TIME_W-1:0]     item_taken_reg, item_taken_next;
    logic                  res_grant_reg, res_grant_next;
    logic                  res_over_reg, res_over_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic                  m_grant_reg, m_grant_next;
    logic [TASK_IDX_W-1:0] m_task_reg, m_task_next;
    logic                  m_over_reg, m_over_next;
    logic [TIME_W-1:0]     m_budget_reg, m_budget_next;

    // divider and scan helpers
    logic [RATE_W-1:0]     rate_sel;
    logic [RATE_W-1:0]     div_quo;
    logic                  div_done;
    logic [RATE_W-1:0]     interval_new;
    logic [TIDX_W-1:0]     fin_idx;
    logic [RATE_W-1:0]     max_sel;
    logic                  exhausted;
    logic [TIDX_W-1:0]     scan_sel;
    logic                  scan_end;
    logic [TIME_W-1:0]     since_run;
    logic                  scan_hit;

    rts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (loop_rate),
        .divisor  (rate_sel),
        .done     (div_done),
        .quotient (div_quo)
    );

    // interval of the task under calculation, never below one
    assign rate_sel     = task_rates[RATE_W*calc_idx_reg +: RATE_W];
    assign interval_new = (rate_sel == '0 || div_quo == '0) ? RATE_W'(1) : div_quo;

    // finish of the granted task
    assign fin_idx   = cur_reg[TIDX_W-1:0];
    assign max_sel   = task_max_times[RATE_W*cur_reg +: RATE_W];
    assign exhausted = item_taken_reg >= budget_reg;

    // due check of one task
    assign scan_sel  = scan_idx_reg[TIDX_W-1:0];
    assign scan_end  = scan_idx_reg >= CNT_W'(N_TASKS);
    assign since_run = tick_reg - prev_run_reg[scan_sel];
    assign scan_hit  = since_run >= {{(TIME_W-RATE_W){1'b0}}, interval_reg[scan_sel]};

    assign status.div_done     = div_done;
    assign status.calc_last    = calc_idx_reg == TIDX_W'(N_TASKS - 1);
    assign status.exec_to_scan = !item_mode_reg || (pend_reg && !exhausted);
    assign status.scan_stop    = scan_end || scan_hit;
    assign status.out_free     = !m_valid_reg || m_ready;

    always_comb begin
        tick_next        = tick_reg;
        prev_run_next    = prev_run_reg;
        budget_next      = budget_reg;
        cur_next         = cur_reg;
        pend_next        = pend_reg;
        interval_next    = interval_reg;
        calc_idx_next    = calc_idx_reg;
        scan_idx_next    = scan_idx_reg;
        item_mode_next   = item_mode_reg;
        item_budget_next = item_budget_reg;
        item_taken_next  = item_taken_reg;
        res_grant_next   = res_grant_reg;
        res_over_next    = res_over_reg;
        m_valid_next     = m_valid_reg;
        m_grant_next     = m_grant_reg;
        m_task_next      = m_task_reg;
        m_over_next      = m_over_reg;
        m_budget_next    = m_budget_reg;

        // interval table fill
        if (cmd.calc_clear) begin
            calc_idx_next = '0;
        end else if (cmd.div_store) begin
            interval_next[calc_idx_reg] = interval_new;
            calc_idx_next = status.calc_last ? '0 : calc_idx_reg + TIDX_W'(1);
        end

        // capture the item
        if (cmd.accept) begin
            item_mode_next   = s_mode;
            item_budget_next = s_budget_us;
            item_taken_next  = s_time_taken_us;
        end

        // first step of the item
        if (cmd.exec) begin
            res_over_next  = 1'b0;
            res_grant_next = 1'b0;
            if (!item_mode_reg) begin
                tick_next     = tick_reg + TIME_W'(1);
                budget_next   = item_budget_reg;
                scan_idx_next = '0;
            end else if (pend_reg) begin
                prev_run_next[fin_idx] = tick_reg;
                res_over_next = item_taken_reg > {{(TIME_W-RATE_W){1'b0}}, max_sel};
                if (exhausted) begin
                    budget_next = '0;
                    pend_next   = 1'b0;
                end else begin
                    budget_next   = budget_reg - item_taken_reg;
                    scan_idx_next = CNT_W'({1'b0, cur_reg} + 3'd1);
                end
            end
        end

        // one task per cycle
        if (cmd.scan_step) begin
            if (scan_end) begin
                pend_next      = 1'b0;
                res_grant_next = 1'b0;
            end else if (scan_hit) begin
                cur_next       = TASK_IDX_W'(scan_sel);
                pend_next      = 1'b1;
                res_grant_next = 1'b1;
            end else begin
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
        end

        // output register
        if (cmd.load_out) begin
            m_valid_next  = 1'b1;
            m_grant_next  = res_grant_reg;
            m_task_next   = res_grant_reg ? cur_reg : '0;
            m_over_next   = res_over_reg;
            m_budget_next = budget_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg     <= '0;
            budget_reg   <= '0;
            cur_reg      <= '0;
            pend_reg     <= 1'b0;
            calc_idx_reg <= '0;
            scan_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < N_TASKS; i++) begin
                prev_run_reg[i] <= '0;
            end
        end else begin
            tick_reg      <= tick_next;
            budget_reg    <= budget_next;
            cur_reg       <= cur_next;
            pend_reg      <= pend_next;
            calc_idx_reg  <= calc_idx_next;
            scan_idx_reg  <= scan_idx_next;
            m_valid_reg   <= m_valid_next;
            prev_run_reg  <= prev_run_next;
        end
    end

    always_ff @(posedge aclk) begin
        interval_reg    <= interval_next;
        item_mode_reg   <= item_mode_next;
        item_budget_reg <= item_budget_next;
        item_taken_reg  <= item_taken_next;
        res_grant_reg   <= res_grant_next;
        res_over_reg    <= res_over_next;
        m_grant_reg     <= m_grant_next;
        m_task_reg      <= m_task_next;
        m_over_reg      <= m_over_next;
        m_budget_reg    <= m_budget_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_grant_valid = m_grant_reg;
    assign m_grant_task  = m_task_reg;
    assign m_overrun     = m_over_reg;
    assign m_tick_done   = !m_grant_reg;
    assign m_budget_left = m_budget_reg;

endmodule

// ===== rtl/rts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rts_ctrl
// Scheduler controller: sequences the interval table fill after reset and
// after rate writes between items, then capture, execution, scan, hand-off.
// ----------------------------------------------------------------------------
module rts_ctrl import rts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        rate_wr,
    input  rts_status_t status,
    output rts_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_CALC_START = 6'b000001,
        ST_CALC_WAIT  = 6'b000010,
        ST_IDLE       = 6'b000100,
        ST_EXEC       = 6'b001000,
        ST_SCAN       = 6'b010000,
        ST_FINISH     = 6'b100000
    } rts_state_t;

    rts_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            // start one division
            ST_CALC_START: begin
                cmd.div_start = 1'b1;
                if (rate_wr) begin
                    cmd.calc_clear = 1'b1;
                end else begin
                    state_next = ST_CALC_WAIT;
                end
            end
            // store the interval, move to the next task
            ST_CALC_WAIT: begin
                if (rate_wr) begin
                    cmd.calc_clear = 1'b1;
                    state_next     = ST_CALC_START;
                end else if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = status.calc_last ? ST_IDLE : ST_CALC_START;
                end
            end
            // wait for an item
            ST_IDLE: begin
                s_ready = !rate_wr;
                if (rate_wr) begin
                    cmd.calc_clear = 1'b1;
                    state_next     = ST_CALC_START;
                end else if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.exec_to_scan ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_stop) begin
                    state_next = ST_FINISH;
                end
            end
            // hand the result to the output register
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CALC_START;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CALC_START;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rate_task_scheduler. Tick and finish items are
// driven on the s_ channel with random gaps while m_ready stalls at random.
// A local model of the scheduler predicts every result at acceptance and
// the result channel is compared field by field. Register sets (including
// rate and limit extremes) are written over the APB port between phases
// and read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rts_pkg::*;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;
    localparam int   NUM_TASKS   = 4;
    localparam int   DRAIN_CYCLES = 12;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   RANDOM_ITEMS = 480;

    typedef struct packed {
        logic                  grant_valid;
        logic [TASK_IDX_W-1:0] grant_task;
        logic                  overrun;
        logic                  tick_done;
        logic [TIME_W-1:0]     budget_left;
    } sched_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_mode;
    logic [TIME_W-1:0]     s_budget_us;
    logic [TIME_W-1:0]     s_time_taken_us;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_grant_valid;
    logic [TASK_IDX_W-1:0] m_grant_task;
    logic                  m_overrun;
    logic                  m_tick_done;
    logic [TIME_W-1:0]     m_budget_left;

    // scheduler model: configuration and state
    logic [RATE_W-1:0]     cfg_loop_rate;
    logic [63:0]           cfg_task_rates;
    logic [63:0]           cfg_task_max;
    logic [TIME_W-1:0]     tick_cnt;
    logic [TIME_W-1:0]     prev_run [NUM_TASKS];
    logic [TIME_W-1:0]     budget_rem;
    int                    run_task;
    logic                  grant_open;

    sched_result_t         results_q [$];
    sched_result_t         next_result;
    int                    error_count;
    int                    items_sent;
    int                    gap_max;
    int                    cycle_cnt;

    rate_task_scheduler uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_budget_us     (s_budget_us),
        .s_time_taken_us (s_time_taken_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_grant_valid   (m_grant_valid),
        .m_grant_task    (m_grant_task),
        .m_overrun       (m_overrun),
        .m_tick_done     (m_tick_done),
        .m_budget_left   (m_budget_left)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial cycle_cnt = 0;
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_error(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // interval of one task: loop rate over task rate, at least one tick
    function automatic logic [TIME_W-1:0] task_interval(int idx);
        logic [RATE_W-1:0] rate;
        logic [TIME_W-1:0] quo;
        rate = cfg_task_rates[idx*RATE_W +: RATE_W];
        if (rate == '0)
            return TIME_W'(1);
        quo = TIME_W'(cfg_loop_rate) / TIME_W'(rate);
        return (quo == '0) ? TIME_W'(1) : quo;
    endfunction

    // grant the first due task at or above start
    function automatic logic scan_tasks(int start);
        logic [TIME_W-1:0] since;
        int i;
        for (i = start; i < NUM_TASKS; i++) begin
            since = tick_cnt - prev_run[i];
            if (since >= task_interval(i)) begin
                run_task   = i;
                grant_open = 1'b1;
                return 1'b1;
            end
        end
        grant_open = 1'b0;
        return 1'b0;
    endfunction

    function automatic sched_result_t sched_predict(logic mode, logic [TIME_W-1:0] budget,
                                                    logic [TIME_W-1:0] taken);
        sched_result_t r;
        int t;
        r = '0;
        if (mode == MODE_TICK) begin
            tick_cnt      = tick_cnt + 1;
            budget_rem    = budget;
            r.grant_valid = scan_tasks(0);
        end else if (grant_open) begin
            t           = run_task;
            prev_run[t] = tick_cnt;
            r.overrun   = (taken > TIME_W'(cfg_task_max[t*RATE_W +: RATE_W]));
            if (taken >= budget_rem) begin
                budget_rem = '0;
                grant_open = 1'b0;
            end else begin
                budget_rem    = budget_rem - taken;
                r.grant_valid = scan_tasks(t + 1);
            end
        end
        r.grant_task  = r.grant_valid ? TASK_IDX_W'(run_task) : '0;
        r.tick_done   = ~r.grant_valid;
        r.budget_left = budget_rem;
        return r;
    endfunction

    // send one item and record its expected result at acceptance
    task automatic send_item(logic mode, logic [TIME_W-1:0] budget, logic [TIME_W-1:0] taken);
        int gap;
        gap = $urandom_range(0, gap_max);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_budget_us     <= budget;
        s_time_taken_us <= taken;
        do @(posedge aclk); while (!s_ready);
        if (mode == MODE_TICK || grant_open)
            items_sent++;
        results_q.push_back(sched_predict(mode, budget, taken));
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one apb transfer, issued only while the item path is idle
    task automatic apb_access(logic write, logic [REG_SEL_W-1:0] idx,
                              logic [63:0] wdata, output logic [63:0] rdata);
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, {REG_SEL_LSB{1'b0}}};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (write) begin
            case (idx)
                REG_LOOP_RATE:  cfg_loop_rate  = wdata[RATE_W-1:0];
                REG_TASK_RATES: cfg_task_rates = wdata;
                REG_TASK_MAX:   cfg_task_max   = wdata;
                default: ;
            endcase
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(logic [REG_SEL_W-1:0] idx, logic [63:0] want);
        logic [63:0] back;
        apb_access(1'b0, idx, '0, back);
        if (back !== want)
            report_error($sformatf("register %0d readback", idx), back, want);
    endtask

    task automatic apply_config(logic [RATE_W-1:0] loop_rate, logic [63:0] rates,
                                logic [63:0] max_times);
        logic [63:0] unused;
        wait_results_drained();
        apb_access(1'b1, REG_LOOP_RATE, 64'(loop_rate), unused);
        check_reg(REG_LOOP_RATE, 64'(loop_rate));
        apb_access(1'b1, REG_TASK_RATES, rates, unused);
        check_reg(REG_TASK_RATES, rates);
        apb_access(1'b1, REG_TASK_MAX, max_times, unused);
        check_reg(REG_TASK_MAX, max_times);
    endtask

    // finish time: mostly short, sometimes the rest, one below it or any value
    function automatic logic [TIME_W-1:0] pick_taken();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return budget_rem;
            2: return (budget_rem == '0) ? '0 : budget_rem - 1;
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_budget();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom;
            default: return $urandom_range(0, 2000);
        endcase
    endfunction

    // a well-formed tick: the tick, then finishes until the tick ends
    task automatic run_tick(logic [TIME_W-1:0] budget, logic allow_cut);
        send_item(MODE_TICK, budget, $urandom);
        while (grant_open && !(allow_cut && $urandom_range(0, 19) == 0))
            send_item(MODE_FINISH, $urandom, pick_taken());
    endtask

    // reset values and a finish item with no grant open
    task automatic test_reset_state();
        check_reg(REG_LOOP_RATE, 64'(LOOP_RATE_RST));
        check_reg(REG_TASK_RATES, TASK_RATES_RST);
        check_reg(REG_TASK_MAX, TASK_MAX_RST);
        send_item(MODE_FINISH, '0, '1);
    endtask

    // default intervals 8/4/2/1 ticks, limits 100/500/200/200 us
    task automatic test_default_schedule();
        send_item(MODE_TICK, '0, '0);          // zero budget still grants
        send_item(MODE_FINISH, '1, '0);        // finish ends the tick
        send_item(MODE_TICK, '1, '0);          // full budget
        send_item(MODE_FINISH, '0, 32'd201);   // over the limit, scan goes on
        send_item(MODE_FINISH, '0, '1);        // eats the rest of the budget
        send_item(MODE_TICK, 32'd1000, '0);
        send_item(MODE_TICK, 32'd500, '0);     // abandons the open grant
        send_item(MODE_FINISH, '0, 32'd500);   // at the limit, equal to budget
        send_item(MODE_FINISH, '0, 32'd7);     // stray finish
        run_tick(32'd100000, 1'b0);            // small times, scan runs past task 3
    endtask

    // rate extremes: zero rate, quotient below one, loop rate at both ends
    task automatic test_rate_extremes();
        apply_config(16'd1, {16'hFFFF, 16'd0, 16'd1, 16'd2},
                     {16'hFFFF, 16'd0, 16'd1, 16'd0});
        run_tick(32'd400, 1'b0);
        run_tick(32'd50, 1'b0);
        apply_config(16'hFFFF, {16'hFFFF, 16'd1, 16'd1, 16'd1},
                     {16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        run_tick(32'd1000, 1'b0);
        run_tick('1, 1'b0);
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return RATE_W'($urandom_range(0, 65535));
            default: return RATE_W'($urandom_range(1, 400));
        endcase
    endfunction

    // random register sets, mostly well-formed ticks with noise mixed in
    task automatic test_random_phases();
        logic [RATE_W-1:0] loop_rate;
        logic [63:0]       rates;
        logic [63:0]       max_times;
        int phase;
        int k;
        int phase_end;
        for (phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 5))
                0: loop_rate = 16'd1;
                1: loop_rate = 16'hFFFF;
                2: loop_rate = RATE_W'($urandom_range(1, 65535));
                default: loop_rate = RATE_W'($urandom_range(100, 1000));
            endcase
            for (k = 0; k < NUM_TASKS; k++) begin
                rates[k*RATE_W +: RATE_W]     = pick_rate();
                max_times[k*RATE_W +: RATE_W] = ($urandom_range(0, 3) == 0) ?
                                                RATE_W'($urandom_range(0, 65535)) :
                                                RATE_W'($urandom_range(0, 400));
            end
            if (phase == 0) begin
                loop_rate = LOOP_RATE_RST;
                rates     = TASK_RATES_RST;
                max_times = TASK_MAX_RST;
            end
            apply_config(loop_rate, rates, max_times);
            gap_max   = (phase == 3) ? 0 : 3;
            phase_end = items_sent + RANDOM_ITEMS / 6;
            while (items_sent < phase_end) begin
                case ($urandom_range(0, 39))
                    0:       wait_results_drained();
                    1, 2:    send_item(MODE_FINISH, $urandom, $urandom);
                    3, 4:    send_item(MODE_TICK, $urandom, $urandom);
                    default: run_tick(pick_budget(), 1'b1);
                endcase
            end
        end
        gap_max = 3;
    endtask

    // result receiver with random stalls
    initial begin
        m_ready = 1'b0;
        forever begin
            repeat ($urandom_range(0, gap_max)) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (results_q.size() == 0) begin
                report_error("result with no item pending", 64'(m_budget_left), '0);
            end else begin
                next_result = results_q.pop_front();
                if (m_grant_valid !== next_result.grant_valid)
                    report_error("grant_valid", 64'(m_grant_valid), 64'(next_result.grant_valid));
                if (m_grant_task !== next_result.grant_task)
                    report_error("grant_task", 64'(m_grant_task), 64'(next_result.grant_task));
                if (m_overrun !== next_result.overrun)
                    report_error("overrun", 64'(m_overrun), 64'(next_result.overrun));
                if (m_tick_done !== next_result.tick_done)
                    report_error("tick_done", 64'(m_tick_done), 64'(next_result.tick_done));
                if (m_budget_left !== next_result.budget_left)
                    report_error("budget_left", 64'(m_budget_left),
                                 64'(next_result.budget_left));
            end
        end
    end

    // main sequence
    initial begin
        int i;
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_valid         = 1'b0;
        s_mode          = MODE_TICK;
        s_budget_us     = '0;
        s_time_taken_us = '0;
        error_count     = 0;
        items_sent      = 0;
        gap_max         = 3;
        cfg_loop_rate   = LOOP_RATE_RST;
        cfg_task_rates  = TASK_RATES_RST;
        cfg_task_max    = TASK_MAX_RST;
        tick_cnt        = '0;
        budget_rem      = '0;
        run_task        = 0;
        grant_open      = 1'b0;
        for (i = 0; i < NUM_TASKS; i++)
            prev_run[i] = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_default_schedule();
        test_rate_extremes();
        test_random_phases();

        wait_results_drained();
        if (results_q.size() != 0)
            report_error("results never returned", 64'(results_q.size()), '0);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== rate_task_scheduler.f =====
rtl/rts_pkg.sv
rtl/rts_regs.sv
rtl/rts_div.sv
rtl/rts_dp.sv
rtl/rts_ctrl.sv
rtl/rate_task_scheduler.sv
sim/tb.sv
